@@ rtl/pls_pkg.sv @@
`default_nettype none
package pls_pkg;
	localparam int CFB = 4;
	localparam int KFB = 40;
	localparam int CW = 20;
	localparam int DW = CW + 1;
	localparam int AW = CW;
	localparam int SQW = 2 * AW;
	localparam int D2W = SQW + 1;
	localparam int RW = 12;
	localparam int RQW = RW + CFB;
	localparam int RQ2W = 2 * RQW;
	localparam int KW = 48;
	localparam int KH = KW / 2;
	localparam int CLRW = 32;
	localparam int CHW = 8;
	localparam int NCH = 3;
	localparam int T1W = KW + RQW - CFB;
	localparam int T2W = KW + RQ2W - 2 * CFB;
	localparam int SUMW = T2W + 1;
	localparam int DENW = 64;
	localparam int DH = DENW / 2;
	localparam int DPW = RQW + DENW;
	localparam int NUMW = CHW + RQW;
	localparam int NW = NUMW + KFB;
	localparam int QW = CHW;
	localparam int CMPW = DPW + QW;
	localparam int IDXW = 3;
	localparam int CFGW = KW;

	localparam logic [SUMW-1:0] DEN_CAP = SUMW'(1) << (DENW - 1);
	localparam logic [CHW-1:0] CH_MAX = '1;

	typedef enum logic [IDXW-1:0] {
		REG_LIGHT_X       = 3'd0,
		REG_LIGHT_Y       = 3'd1,
		REG_LIGHT_RADIUS  = 3'd2,
		REG_FALLOFF_CONST = 3'd3,
		REG_FALLOFF_LIN   = 3'd4,
		REG_FALLOFF_QUAD  = 3'd5,
		REG_LIGHT_COLOR   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic lit;
	} ctl_t;
endpackage
`default_nettype wire

@@ rtl/pls_if.sv @@
`default_nettype none
interface pls_pix_if;
	logic valid;
	logic ready;
	logic signed [pls_pkg::CW-1:0] pixel_x;
	logic signed [pls_pkg::CW-1:0] pixel_y;
	modport source(output valid, pixel_x, pixel_y, input ready);
	modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

interface pls_rgb_if;
	logic valid;
	logic ready;
	logic [pls_pkg::CHW-1:0] red;
	logic [pls_pkg::CHW-1:0] green;
	logic [pls_pkg::CHW-1:0] blue;
	logic [pls_pkg::CHW-1:0] alpha;
	logic inside_res;
	modport source(output valid, red, green, blue, alpha, inside_res, input ready);
	modport sink(input valid, red, green, blue, alpha, inside_res, output ready);
endinterface
`default_nettype wire

@@ rtl/pls_cfg.sv @@
`default_nettype none
module pls_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        we,
	input  wire logic [pls_pkg::IDXW-1:0]    idx,
	input  wire logic [pls_pkg::CFGW-1:0]    wdata,
	output logic signed [pls_pkg::CW-1:0]    light_x,
	output logic signed [pls_pkg::CW-1:0]    light_y,
	output logic [pls_pkg::RQW-1:0]          rq,
	output logic [pls_pkg::RQ2W-1:0]         rq_sq,
	output logic [pls_pkg::KW-1:0]           k0,
	output logic [pls_pkg::KW-1:0]           k1,
	output logic [pls_pkg::KW-1:0]           k2,
	output logic [pls_pkg::CLRW-1:0]         color
);
	logic [pls_pkg::CW-1:0] lx_q, ly_q;
	logic [pls_pkg::RW-1:0] radius_q;
	logic [pls_pkg::KW-1:0] k0_q, k1_q, k2_q;
	logic [pls_pkg::CLRW-1:0] color_q;
	logic [pls_pkg::RQ2W-1:0] rq_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q     <= '0;
			ly_q     <= '0;
			radius_q <= pls_pkg::RW'(500);
			k0_q     <= pls_pkg::KW'(48'd1319413953331);
			k1_q     <= pls_pkg::KW'(48'd549755814);
			k2_q     <= pls_pkg::KW'(48'd219902);
			color_q  <= '1;
			rq_sq_q  <= pls_pkg::RQ2W'(32'd64000000);
		end else begin
			rq_sq_q <= rq * rq;
			if (we) begin
				case (pls_pkg::reg_idx_t'(idx))
					pls_pkg::REG_LIGHT_X:       lx_q     <= wdata[pls_pkg::CW-1:0];
					pls_pkg::REG_LIGHT_Y:       ly_q     <= wdata[pls_pkg::CW-1:0];
					pls_pkg::REG_LIGHT_RADIUS:  radius_q <= wdata[pls_pkg::RW-1:0];
					pls_pkg::REG_FALLOFF_CONST: k0_q     <= wdata[pls_pkg::KW-1:0];
					pls_pkg::REG_FALLOFF_LIN:   k1_q     <= wdata[pls_pkg::KW-1:0];
					pls_pkg::REG_FALLOFF_QUAD:  k2_q     <= wdata[pls_pkg::KW-1:0];
					pls_pkg::REG_LIGHT_COLOR:   color_q  <= wdata[pls_pkg::CLRW-1:0];
					default: ;
				endcase
			end
		end
	end

	assign light_x = lx_q;
	assign light_y = ly_q;
	assign rq = {radius_q, pls_pkg::CFB'(0)};
	assign rq_sq = rq_sq_q;
	assign k0 = k0_q;
	assign k1 = k1_q;
	assign k2 = k2_q;
	assign color = color_q;
endmodule
`default_nettype wire

@@ rtl/pls_geom.sv @@
`default_nettype none
module pls_geom (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            in_valid,
	input  wire logic signed [pls_pkg::CW-1:0]   px,
	input  wire logic signed [pls_pkg::CW-1:0]   py,
	input  wire logic signed [pls_pkg::CW-1:0]   lx,
	input  wire logic signed [pls_pkg::CW-1:0]   ly,
	input  wire logic [pls_pkg::RQ2W-1:0]        rq_sq,
	output pls_pkg::ctl_t                        ctl,
	output logic [pls_pkg::RQ2W-1:0]             d2
);
	logic v_s1, v_s2, v_s3;
	pls_pkg::ctl_t ctl_s4;
	logic signed [pls_pkg::DW-1:0] dx_s1, dy_s1;
	logic [pls_pkg::AW-1:0] ax_s2, ay_s2;
	logic [pls_pkg::SQW-1:0] sx_s3, sy_s3;
	logic [pls_pkg::RQ2W-1:0] d2_s4;
	logic [pls_pkg::DW-1:0] nx, ny;
	logic [pls_pkg::D2W-1:0] sum;

	assign nx = -dx_s1;
	assign ny = -dy_s1;
	assign sum = pls_pkg::D2W'(sx_s3) + pls_pkg::D2W'(sy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			ctl_s4 <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			ctl_s4.valid <= v_s3;
			ctl_s4.lit   <= sum <= pls_pkg::D2W'(rq_sq);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= pls_pkg::DW'(lx) - pls_pkg::DW'(px);
			dy_s1 <= pls_pkg::DW'(ly) - pls_pkg::DW'(py);
			ax_s2 <= dx_s1[pls_pkg::DW-1] ? nx[pls_pkg::AW-1:0] : dx_s1[pls_pkg::AW-1:0];
			ay_s2 <= dy_s1[pls_pkg::DW-1] ? ny[pls_pkg::AW-1:0] : dy_s1[pls_pkg::AW-1:0];
			sx_s3 <= ax_s2 * ax_s2;
			sy_s3 <= ay_s2 * ay_s2;
			d2_s4 <= sum[pls_pkg::RQ2W-1:0];
		end
	end

	assign ctl = ctl_s4;
	assign d2 = d2_s4;
endmodule
`default_nettype wire

@@ rtl/pls_isqrt.sv @@
`default_nettype none
module pls_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire pls_pkg::ctl_t               in_ctl,
	input  wire logic [pls_pkg::RQ2W-1:0]    in_d2,
	output pls_pkg::ctl_t                    ctl,
	output logic [pls_pkg::RQ2W-1:0]         d2,
	output logic [pls_pkg::RQW-1:0]          root
);
	localparam int N = pls_pkg::RQW;

	logic [pls_pkg::RQ2W-1:0] v_s [0:N];
	logic [pls_pkg::RQ2W-1:0] r_s [0:N];
	logic [pls_pkg::RQ2W-1:0] d2_s [0:N];
	pls_pkg::ctl_t ctl_s [0:N];

	assign v_s[0] = in_d2;
	assign r_s[0] = '0;
	assign d2_s[0] = in_d2;
	assign ctl_s[0] = in_ctl;

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic [pls_pkg::RQ2W-1:0] BIT = pls_pkg::RQ2W'(1) << (2 * (N - 1 - i));
		logic [pls_pkg::RQ2W-1:0] t;
		assign t = r_s[i] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (en) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d2_s[i+1] <= d2_s[i];
				if (v_s[i] >= t) begin
					v_s[i+1] <= v_s[i] - t;
					r_s[i+1] <= (r_s[i] >> 1) + BIT;
				end else begin
					v_s[i+1] <= v_s[i];
					r_s[i+1] <= r_s[i] >> 1;
				end
			end
		end
	end

	assign ctl = ctl_s[N];
	assign d2 = d2_s[N];
	assign root = r_s[N][pls_pkg::RQW-1:0];
endmodule
`default_nettype wire

@@ rtl/pls_denom.sv @@
`default_nettype none
module pls_denom (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire pls_pkg::ctl_t               in_ctl,
	input  wire logic [pls_pkg::RQW-1:0]     d,
	input  wire logic [pls_pkg::RQ2W-1:0]    d2,
	input  wire logic [pls_pkg::RQW-1:0]     rq,
	input  wire logic [pls_pkg::KW-1:0]      k0,
	input  wire logic [pls_pkg::KW-1:0]      k1,
	input  wire logic [pls_pkg::KW-1:0]      k2,
	input  wire logic [pls_pkg::CLRW-1:0]    color,
	output pls_pkg::ctl_t                    ctl,
	output logic [pls_pkg::DENW-1:0]         den,
	output logic [pls_pkg::NUMW-1:0]         num [pls_pkg::NCH]
);
	localparam int PW = pls_pkg::KH + pls_pkg::RQ2W;
	localparam int FW = pls_pkg::KW + pls_pkg::RQ2W;

	pls_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [pls_pkg::KW+pls_pkg::RQW-1:0] t1_s1;
	logic [PW-1:0] pl_s1, ph_s1;
	logic [pls_pkg::RQW-1:0] rem_s1;
	logic [pls_pkg::T1W:0] sum1_s2;
	logic [pls_pkg::T2W-1:0] t2_s2;
	logic [pls_pkg::NUMW-1:0] num_s2 [pls_pkg::NCH];
	logic [pls_pkg::NUMW-1:0] num_s3 [pls_pkg::NCH];
	logic [pls_pkg::DENW-1:0] den_s3;
	logic [FW-1:0] full;
	logic [pls_pkg::SUMW-1:0] sum;

	assign full = {ph_s1, pls_pkg::KH'(0)} + FW'(pl_s1);
	assign sum = pls_pkg::SUMW'(sum1_s2) + pls_pkg::SUMW'(t2_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s1  <= k1 * d;
			pl_s1  <= k2[pls_pkg::KH-1:0] * d2;
			ph_s1  <= k2[pls_pkg::KW-1:pls_pkg::KH] * d2;
			rem_s1 <= rq - d;
			sum1_s2 <= (pls_pkg::T1W+1)'(k0)
				+ (pls_pkg::T1W+1)'(t1_s1[pls_pkg::KW+pls_pkg::RQW-1:pls_pkg::CFB]);
			t2_s2 <= full[FW-1:2*pls_pkg::CFB];
			for (int c = 0; c < pls_pkg::NCH; c++) begin
				num_s2[c] <= color[pls_pkg::CLRW-1-pls_pkg::CHW*c -: pls_pkg::CHW] * rem_s1;
			end
			num_s3 <= num_s2;
			den_s3 <= (sum > pls_pkg::DEN_CAP) ? pls_pkg::DEN_CAP[pls_pkg::DENW-1:0]
			                                   : sum[pls_pkg::DENW-1:0];
		end
	end

	assign ctl = ctl_s3;
	assign den = den_s3;
	assign num = num_s3;
endmodule
`default_nettype wire

@@ rtl/pls_div.sv @@
`default_nettype none
module pls_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire pls_pkg::ctl_t               in_ctl,
	input  wire logic [pls_pkg::DENW-1:0]    den,
	input  wire logic [pls_pkg::RQW-1:0]     rq,
	input  wire logic [pls_pkg::NUMW-1:0]    num [pls_pkg::NCH],
	output pls_pkg::ctl_t                    ctl,
	output logic [pls_pkg::QW-1:0]           q [pls_pkg::NCH]
);
	localparam int PW = pls_pkg::RQW + pls_pkg::DH;
	localparam int NS = pls_pkg::QW;

	pls_pkg::ctl_t ctl_a, ctl_b;
	logic [PW-1:0] pl_a, ph_a;
	logic denz_a, denz_b;
	logic [pls_pkg::NUMW-1:0] num_a [pls_pkg::NCH];
	logic [pls_pkg::NUMW-1:0] num_b [pls_pkg::NCH];
	logic [pls_pkg::DPW-1:0] dp_b;

	logic [pls_pkg::NW-1:0] rem_s [0:NS][pls_pkg::NCH];
	logic [pls_pkg::QW-1:0] q_s [0:NS][pls_pkg::NCH];
	logic fin_s [0:NS][pls_pkg::NCH];
	logic [pls_pkg::DPW-1:0] dp_s [0:NS];
	pls_pkg::ctl_t ctl_s [0:NS];

	logic [pls_pkg::CMPW-1:0] lim;
	assign lim = pls_pkg::CMPW'(dp_b) << pls_pkg::QW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_a <= '0;
			ctl_b <= '0;
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_a <= in_ctl;
			ctl_b <= ctl_a;
			ctl_s[0] <= ctl_b;
		end
	end

	always_ff @(posedge clk) begin
		logic [pls_pkg::NW-1:0] n;
		logic sat;
		if (en) begin
			pl_a   <= rq * den[pls_pkg::DH-1:0];
			ph_a   <= rq * den[pls_pkg::DENW-1:pls_pkg::DH];
			denz_a <= den == '0 || rq == '0;
			num_a  <= num;
			dp_b   <= {ph_a, pls_pkg::DH'(0)} + pls_pkg::DPW'(pl_a);
			denz_b <= denz_a;
			num_b  <= num_a;
			dp_s[0] <= dp_b;
			for (int c = 0; c < pls_pkg::NCH; c++) begin
				n = {num_b[c], pls_pkg::KFB'(0)};
				sat = num_b[c] != '0 && (denz_b || pls_pkg::CMPW'(n) >= lim);
				rem_s[0][c] <= n;
				q_s[0][c]   <= sat ? pls_pkg::CH_MAX : '0;
				fin_s[0][c] <= sat || num_b[c] == '0;
			end
		end
	end

	for (genvar j = 0; j < NS; j++) begin : g_step
		localparam int K = NS - 1 - j;
		logic [pls_pkg::CMPW-1:0] dk;
		assign dk = pls_pkg::CMPW'(dp_s[j]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j+1] <= '0;
			end else if (en) begin
				ctl_s[j+1] <= ctl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			logic [pls_pkg::CMPW-1:0] diff;
			if (en) begin
				dp_s[j+1] <= dp_s[j];
				for (int c = 0; c < pls_pkg::NCH; c++) begin
					diff = pls_pkg::CMPW'(rem_s[j][c]) - dk;
					fin_s[j+1][c] <= fin_s[j][c];
					if (!fin_s[j][c] && pls_pkg::CMPW'(rem_s[j][c]) >= dk) begin
						rem_s[j+1][c] <= diff[pls_pkg::NW-1:0];
						q_s[j+1][c]   <= q_s[j][c] | (pls_pkg::QW'(1) << K);
					end else begin
						rem_s[j+1][c] <= rem_s[j][c];
						q_s[j+1][c]   <= q_s[j][c];
					end
				end
			end
		end
	end

	assign ctl = ctl_s[NS];
	assign q = q_s[NS];
endmodule
`default_nettype wire

@@ rtl/point_light_shade.sv @@
// the path from pixel transaction to result valid is mostly the 16-step root
// and 8-step quotient stages
// throughput: one pixel per cycle unless stalled; every step is a register stage
// with its own valid bit; a held result stalls every stage together, nothing is dropped
// or repeated; reset clears all valid bits and loads the register reset values
`default_nettype none
module point_light_shade (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [pls_pkg::IDXW-1:0]    cfg_idx,
	input  wire logic [pls_pkg::CFGW-1:0]    cfg_wdata,
	pls_pix_if.sink                          pix,
	pls_rgb_if.source                        rgb
);
	logic en;
	logic signed [pls_pkg::CW-1:0] lx, ly;
	logic [pls_pkg::RQW-1:0] rq;
	logic [pls_pkg::RQ2W-1:0] rq_sq;
	logic [pls_pkg::KW-1:0] k0, k1, k2;
	logic [pls_pkg::CLRW-1:0] color;

	pls_pkg::ctl_t g_ctl, r_ctl, n_ctl, o_ctl;
	logic [pls_pkg::RQ2W-1:0] g_d2, r_d2;
	logic [pls_pkg::RQW-1:0] root;
	logic [pls_pkg::DENW-1:0] den;
	logic [pls_pkg::NUMW-1:0] num [pls_pkg::NCH];
	logic [pls_pkg::QW-1:0] q [pls_pkg::NCH];

	assign en = !o_ctl.valid || rgb.ready;
	assign pix.ready = en;

	pls_cfg u_cfg (
		.clk, .arst_n, .we(cfg_we), .idx(cfg_idx), .wdata(cfg_wdata),
		.light_x(lx), .light_y(ly), .rq, .rq_sq, .k0, .k1, .k2, .color
	);

	pls_geom u_geom (
		.clk, .arst_n, .en, .in_valid(pix.valid), .px(pix.pixel_x), .py(pix.pixel_y),
		.lx, .ly, .rq_sq, .ctl(g_ctl), .d2(g_d2)
	);

	pls_isqrt u_isqrt (
		.clk, .arst_n, .en, .in_ctl(g_ctl), .in_d2(g_d2),
		.ctl(r_ctl), .d2(r_d2), .root
	);

	pls_denom u_denom (
		.clk, .arst_n, .en, .in_ctl(r_ctl), .d(root), .d2(r_d2), .rq,
		.k0, .k1, .k2, .color, .ctl(n_ctl), .den, .num
	);

	pls_div u_div (
		.clk, .arst_n, .en, .in_ctl(n_ctl), .den, .rq, .num, .ctl(o_ctl), .q
	);

	assign rgb.valid = o_ctl.valid;
	assign rgb.inside_res = o_ctl.lit;
	assign rgb.red = o_ctl.lit ? q[0] : '0;
	assign rgb.green = o_ctl.lit ? q[1] : '0;
	assign rgb.blue = o_ctl.lit ? q[2] : '0;
	assign rgb.alpha = o_ctl.lit ? color[pls_pkg::CHW-1:0] : pls_pkg::CH_MAX;
endmodule
`default_nettype wire
